// File: rtl/hbr_pkg.sv
// ============================================================================
// hbr_pkg: shared types and constants for the dual H-bridge soft ramp driver
// Command codes, motion codes, sequencer phase, register map, state record
// and the small lookup functions used by the step logic.
// ============================================================================
`default_nettype none

package hbr_pkg;

	// Full-scale PWM level, used to invert the duty of a reversing motor
	localparam logic [7:0] PWM_FULL = 8'd255;

	// Command codes
	localparam logic [3:0] CMD_FWD       = 4'd0;
	localparam logic [3:0] CMD_REV       = 4'd1;
	localparam logic [3:0] CMD_SPIN_R    = 4'd2;
	localparam logic [3:0] CMD_SPIN_L    = 4'd3;
	localparam logic [3:0] CMD_BRAKE     = 4'd4;
	localparam logic [3:0] CMD_ONE_FWD   = 4'd5;
	localparam logic [3:0] CMD_ONE_REV   = 4'd6;
	localparam logic [3:0] CMD_TWO_FWD   = 4'd7;
	localparam logic [3:0] CMD_TWO_REV   = 4'd8;
	localparam logic [3:0] CMD_BRAKE_ONE = 4'd9;
	localparam logic [3:0] CMD_BRAKE_TWO = 4'd10;
	localparam logic [3:0] CMD_EN_ON     = 4'd11;
	localparam logic [3:0] CMD_EN_OFF    = 4'd12;

	// Operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	// Motion codes
	localparam logic [1:0] MOT_NONE = 2'd0;
	localparam logic [1:0] MOT_FWD  = 2'd1;
	localparam logic [1:0] MOT_REV  = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_RAMP_STEP  = 2'd0;
	localparam logic [1:0] REG_WAIT_TICKS = 2'd1;
	localparam logic [1:0] REG_MAX_DUTY_A = 2'd2;
	localparam logic [1:0] REG_MAX_DUTY_B = 2'd3;

	// Sequencer phase
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_BRAKE = 3'b010,
		PH_RAMP  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] ramp_step;
		logic [7:0] wait_ticks;
		logic [7:0] max_duty_a;
		logic [7:0] max_duty_b;
	} hbr_cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] motion_a;
		logic [1:0] motion_b;
		logic [8:0] ramp_level;
		logic [3:0] active_cmd;
		logic [7:0] tick_count;
		logic [7:0] pwm_a;
		logic [7:0] pwm_b;
		logic       dir_a;
		logic       dir_b;
		logic       enable;
		logic [7:0] start_hold;
	} hbr_state_t;

	localparam hbr_state_t ST_RESET = '{
		phase:      PH_IDLE,
		motion_a:   MOT_NONE,
		motion_b:   MOT_NONE,
		ramp_level: 9'd0,
		active_cmd: CMD_FWD,
		tick_count: 8'd0,
		pwm_a:      8'd0,
		pwm_b:      8'd0,
		dir_a:      1'b0,
		dir_b:      1'b0,
		enable:     1'b0,
		start_hold: 8'd0
	};

	// Target motion of motor one for a command
	function automatic logic [1:0] tgt_a(input logic [3:0] cmd);
		logic [1:0] m;
		unique case (cmd) inside
			CMD_FWD, CMD_SPIN_R, CMD_ONE_FWD: m = MOT_FWD;
			CMD_REV, CMD_SPIN_L, CMD_ONE_REV: m = MOT_REV;
			default:                          m = MOT_NONE;
		endcase
		return m;
	endfunction

	// Target motion of motor two for a command
	function automatic logic [1:0] tgt_b(input logic [3:0] cmd);
		logic [1:0] m;
		unique case (cmd) inside
			CMD_FWD, CMD_SPIN_L, CMD_TWO_FWD: m = MOT_FWD;
			CMD_REV, CMD_SPIN_R, CMD_TWO_REV: m = MOT_REV;
			default:                          m = MOT_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] opposite(input logic [1:0] m);
		logic [1:0] o;
		o = (m == MOT_FWD) ? MOT_REV : ((m == MOT_REV) ? MOT_FWD : MOT_NONE);
		return o;
	endfunction

	// Drive level: inverted only when reversing
	function automatic logic [7:0] drive_lvl(input logic [1:0] m, input logic [7:0] d);
		logic [7:0] v;
		v = (m == MOT_REV) ? (PWM_FULL - d) : d;
		return v;
	endfunction

	// Single-motor brake level: inverted unless running forward
	function automatic logic [7:0] single_lvl(input logic [1:0] m, input logic [7:0] d);
		logic [7:0] v;
		v = (m == MOT_FWD) ? d : (PWM_FULL - d);
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/dual_hbridge_soft_ramp.sv
// ============================================================================
// dual_hbridge_soft_ramp: two-motor H-bridge driver with soft ramps
// Input register, one pass of sequencer logic, result register.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item:
//   a time tick (operation 0) or a command with its start duty (operation 1).
//   Output channel (out_valid / out_stall) returns exactly one result per
//   input transaction: both PWM levels, direction pins, bridge enable, the
//   busy flag and the rejected flag.
//   Path: a transaction accepted into the input register moves on into
//   the state and result registers once the result side can take it;
//   while the receiver stalls it waits in the input register.
//   Throughput: one transaction per cycle unless the receiver stalls, set by
//   the single sequencer pass from the input register to state and result regs.
//   When the receiver stalls, the result holds and the input register keeps
//   its transaction; in_stall rises only while both are full.
//   Reset clears the registers to step 4, wait 2, maxima 255, and the
//   sequencer to idle with all outputs low.
//   Configuration writes take effect on the next transaction processed.
// ============================================================================
`default_nettype none

module dual_hbridge_soft_ramp (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       operation,
	input  wire logic [3:0] command,
	input  wire logic [7:0] start_duty,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      pwm_a,
	output logic [7:0]      pwm_b,
	output logic            dir_a,
	output logic            dir_b,
	output logic            enable_out,
	output logic            busy_res,
	output logic            rejected
);
	import hbr_pkg::*;

	hbr_cfg_t   cfg;
	hbr_state_t st_q;
	hbr_state_t st_nxt;
	logic       rej_nxt;

	logic       valid_s1;
	logic       op_s1;
	logic [3:0] cmd_s1;
	logic [7:0] duty_s1;

	logic       out_valid_q;
	logic       rej_q;
	logic       advance;
	logic       fire;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	hbr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hbr_step u_step (
		.cur        (st_q),
		.cfg        (cfg),
		.operation  (op_s1),
		.command    (cmd_s1),
		.start_duty (duty_s1),
		.nxt        (st_nxt),
		.rejected   (rej_nxt)
	);

	// Hold the input transaction until the result side can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			cmd_s1  <= command;
			duty_s1 <= start_duty;
		end
	end

	// Advance the sequencer state and the result register together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RESET;
			out_valid_q <= 1'b0;
			rej_q       <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				st_q  <= st_nxt;
				rej_q <= rej_nxt;
			end
		end
	end

	// Results come from the state and rej_q, which only move with a transaction
	assign out_valid  = out_valid_q;
	assign pwm_a      = st_q.pwm_a;
	assign pwm_b      = st_q.pwm_b;
	assign dir_a      = st_q.dir_a;
	assign dir_b      = st_q.dir_b;
	assign enable_out = st_q.enable;
	assign busy_res   = (st_q.phase != PH_IDLE);
	assign rejected   = rej_q;

endmodule

`default_nettype wire

// File: rtl/hbr_cfg.sv
// ============================================================================
// hbr_cfg: configuration register file
// Holds ramp step, tick wait and the per-motor maximum duties; written
// through a plain write port, no read-back.
// ============================================================================
`default_nettype none

module hbr_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	output hbr_pkg::hbr_cfg_t      cfg
);
	import hbr_pkg::*;

	hbr_cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step  <= 8'd4;
			cfg_q.wait_ticks <= 8'd2;
			cfg_q.max_duty_a <= 8'd255;
			cfg_q.max_duty_b <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RAMP_STEP:  cfg_q.ramp_step  <= cfg_data;
				REG_WAIT_TICKS: cfg_q.wait_ticks <= cfg_data;
				REG_MAX_DUTY_A: cfg_q.max_duty_a <= cfg_data;
				REG_MAX_DUTY_B: cfg_q.max_duty_b <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/hbr_step.sv
// ============================================================================
// hbr_step: next-state logic of the ramp and brake sequencer
// Takes the current state, the registers and one transaction and returns
// the state after it, plus the rejection flag.
// ============================================================================
`default_nettype none

module hbr_step (
	input  wire hbr_pkg::hbr_state_t cur,
	input  wire hbr_pkg::hbr_cfg_t   cfg,
	input  wire logic                operation,
	input  wire logic [3:0]          command,
	input  wire logic [7:0]          start_duty,
	output hbr_pkg::hbr_state_t      nxt,
	output logic                     rejected
);
	import hbr_pkg::*;

	logic [7:0] step_eff;
	logic [7:0] wait_eff;
	logic [7:0] tick_inc;
	logic       both_moving;
	logic       need_brake;

	// Zero step or wait counts as one
	assign step_eff    = (cfg.ramp_step == 8'd0) ? 8'd1 : cfg.ramp_step;
	assign wait_eff    = (cfg.wait_ticks == 8'd0) ? 8'd1 : cfg.wait_ticks;
	assign tick_inc    = (cur.tick_count != PWM_FULL) ? cur.tick_count + 8'd1 : cur.tick_count;
	assign both_moving = (cur.motion_a != MOT_NONE) && (cur.motion_b != MOT_NONE);
	assign need_brake  = (cur.motion_a == opposite(tgt_a(command))) ||
	                     (cur.motion_b == opposite(tgt_b(command)));

	always_comb begin
		logic       do_brake;
		logic       do_ramp;
		logic [3:0] ac;
		logic [8:0] lvl;
		logic       brk_last;
		logic [7:0] brk_d;
		logic [1:0] ta;
		logic [1:0] tb;
		logic [9:0] lvl_sum;
		logic       done_a;
		logic       done_b;

		nxt      = cur;
		rejected = 1'b0;
		do_brake = 1'b0;
		do_ramp  = 1'b0;

		// Accept a command or count a tick
		if (operation == OP_CMD) begin
			if (cur.phase != PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				nxt.tick_count = 8'd0;
				nxt.active_cmd = command;
				nxt.ramp_level = {1'b0, start_duty};
				nxt.start_hold = start_duty;
				unique case (command) inside
					CMD_FWD, CMD_REV, CMD_SPIN_R, CMD_SPIN_L: begin
						if (need_brake && both_moving) begin
							nxt.phase = PH_BRAKE;
							do_brake  = 1'b1;
						end else begin
							nxt.phase = PH_RAMP;
							do_ramp   = 1'b1;
						end
					end
					CMD_BRAKE: begin
						if (both_moving) begin
							nxt.phase = PH_BRAKE;
							do_brake  = 1'b1;
						end
					end
					CMD_ONE_FWD, CMD_ONE_REV, CMD_TWO_FWD, CMD_TWO_REV: begin
						nxt.phase = PH_RAMP;
						do_ramp   = 1'b1;
					end
					CMD_BRAKE_ONE, CMD_BRAKE_TWO: begin
						nxt.phase = PH_BRAKE;
						do_brake  = 1'b1;
					end
					CMD_EN_ON:  nxt.enable = 1'b1;
					CMD_EN_OFF: nxt.enable = 1'b0;
					default: ;
				endcase
			end
		end else if (cur.phase != PH_IDLE) begin
			nxt.tick_count = tick_inc;
			if (tick_inc >= wait_eff) begin
				nxt.tick_count = 8'd0;
				if (cur.phase == PH_BRAKE) begin
					do_brake = 1'b1;
				end else begin
					do_ramp = 1'b1;
				end
			end
		end

		ac       = nxt.active_cmd;
		lvl      = nxt.ramp_level;
		brk_last = (lvl <= {1'b0, step_eff});
		brk_d    = brk_last ? 8'd0 : lvl[7:0];
		ta       = tgt_a(ac);
		tb       = tgt_b(ac);
		lvl_sum  = {1'b0, lvl} + {2'b0, step_eff};
		done_a   = 1'b1;
		done_b   = 1'b1;

		// Brake step: fall by the step, finish at zero
		if (do_brake) begin
			if (ac == CMD_BRAKE_ONE) begin
				nxt.pwm_a = single_lvl(cur.motion_a, brk_d);
			end else if (ac == CMD_BRAKE_TWO) begin
				nxt.pwm_b = single_lvl(cur.motion_b, brk_d);
			end else begin
				nxt.pwm_a = drive_lvl(cur.motion_a, brk_d);
				nxt.pwm_b = drive_lvl(cur.motion_b, brk_d);
			end
			if (brk_last) begin
				if (ac <= CMD_SPIN_L) begin
					nxt.phase      = PH_RAMP;
					nxt.ramp_level = {1'b0, nxt.start_hold};
				end else begin
					nxt.phase = PH_IDLE;
				end
			end else begin
				nxt.ramp_level = lvl - {1'b0, step_eff};
			end
		end

		// Ramp step: climb by the step, finish at each motor's maximum
		if (do_ramp) begin
			if (ta != MOT_NONE) begin
				done_a       = (lvl_sum >= {2'b0, cfg.max_duty_a});
				nxt.motion_a = ta;
				nxt.pwm_a    = drive_lvl(ta, done_a ? cfg.max_duty_a : lvl[7:0]);
				nxt.dir_a    = (ta == MOT_REV);
			end
			if (tb != MOT_NONE) begin
				done_b       = (lvl_sum >= {2'b0, cfg.max_duty_b});
				nxt.motion_b = tb;
				nxt.pwm_b    = drive_lvl(tb, done_b ? cfg.max_duty_b : lvl[7:0]);
				nxt.dir_b    = (tb == MOT_REV);
			end
			if (done_a && done_b) begin
				nxt.phase = PH_IDLE;
			end else begin
				nxt.ramp_level = lvl_sum[8:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/hbr_chk.sv
// ============================================================================
// hbr_chk: port-level checks for the dual H-bridge soft ramp driver
// Watches the top-level ports only; attached by a bind statement.
// ============================================================================
`default_nettype none

module hbr_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] pwm_a,
	input wire logic [7:0] pwm_b,
	input wire logic       dir_a,
	input wire logic       dir_b,
	input wire logic       enable_out,
	input wire logic       busy_res,
	input wire logic       rejected
);

	// A rejected command leaves the running sequence busy
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res)
		else $error("rejected result without busy");

	// Back-pressure reaches the input only through a stalled, full result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// Drive levels move only together with a new result
	a_no_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> out_valid || ($stable(pwm_a) && $stable(pwm_b) && $stable(busy_res)))
		else $error("outputs changed without a transaction");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pwm_a) && $stable(pwm_b)
			&& $stable(dir_a) && $stable(dir_b) && $stable(enable_out)
			&& $stable(busy_res) && $stable(rejected))
		else $error("stalled result changed");

endmodule

bind dual_hbridge_soft_ramp hbr_chk u_hbr_chk (.*);

`default_nettype wire

// File: sim/dual_hbridge_soft_ramp_test.sv
// ----------------------------------------------------------------------------
// dual_hbridge_soft_ramp_test: self-checking bench for the soft ramp driver
// A short scripted sequence covers reset values, both brake flavours,
// direction changes, busy refusal and zero step or wait. Random traffic then
// runs under several register settings. Each result is compared against a
// cycle-free model of the sequencer in the bench, or a fixed script value.
// ----------------------------------------------------------------------------
module dual_hbridge_soft_ramp_test;
	import hbr_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD     = 64;
	localparam int ROWS          = 32;

	// command codes with no meaning to the block
	localparam logic [3:0] CMD_UNUSED     = 4'd13;
	localparam logic [3:0] CMD_UNUSED_TOP = 4'd15;

	typedef struct packed {
		logic [7:0] pwm_a;
		logic [7:0] pwm_b;
		logic       dir_a;
		logic       dir_b;
		logic       enable;
		logic       busy;
		logic       rejected;
	} drive_t;

	typedef enum logic [1:0] {
		ROW_TICK,
		ROW_CMD,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [3:0] sel;
		logic [7:0] val;
		logic       typed;
		drive_t     fixed;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       operation;
	logic [3:0] command;
	logic [7:0] start_duty;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] pwm_a;
	logic [7:0] pwm_b;
	logic       dir_a;
	logic       dir_b;
	logic       enable_out;
	logic       busy_res;
	logic       rejected;

	// bridge outputs still owed by the block, oldest first
	drive_t pending_drive[$];

	// sequencer model: registers and state
	logic [7:0] st_step, st_wait, st_max_a, st_max_b;
	logic [1:0] st_mot_a, st_mot_b;
	logic [8:0] st_level;
	phase_t     seq_phase;
	logic [3:0] st_cmd;
	logic [7:0] st_ticks;
	logic [7:0] st_pwm_a, st_pwm_b;
	logic       st_dir_a, st_dir_b, st_en;
	logic [7:0] st_hold;

	int  cycles;
	int  mismatches;
	int  results_seen;
	int  n_taken, n_refused, n_timed, n_settings;
	bit  tx_flat, rx_flat, long_hold_req;

	stim_row_t script [ROWS];

	dual_hbridge_soft_ramp dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("run stopped by watchdog after %0d cycles", cycles);
			$display("FAIL dual_hbridge_soft_ramp");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequencer model
	// ------------------------------------------------------------------
	function automatic logic [1:0] aim_of(input logic [3:0] cmd, input logic motor_two);
		logic [1:0] m;
		case (cmd)
			CMD_FWD:     m = MOT_FWD;
			CMD_REV:     m = MOT_REV;
			CMD_SPIN_R:  m = motor_two ? MOT_REV : MOT_FWD;
			CMD_SPIN_L:  m = motor_two ? MOT_FWD : MOT_REV;
			CMD_ONE_FWD: m = motor_two ? MOT_NONE : MOT_FWD;
			CMD_ONE_REV: m = motor_two ? MOT_NONE : MOT_REV;
			CMD_TWO_FWD: m = motor_two ? MOT_FWD : MOT_NONE;
			CMD_TWO_REV: m = motor_two ? MOT_REV : MOT_NONE;
			default:     m = MOT_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] counter_motion(input logic [1:0] m);
		logic [1:0] o;
		if (m == MOT_FWD)
			o = MOT_REV;
		else if (m == MOT_REV)
			o = MOT_FWD;
		else
			o = MOT_NONE;
		return o;
	endfunction

	// a zero step counts as one
	function automatic logic [8:0] step_size();
		logic [8:0] s;
		s = (st_step == 8'd0) ? 9'd1 : {1'b0, st_step};
		return s;
	endfunction

	function automatic logic [7:0] rev_inverted(input logic [1:0] m, input logic [7:0] d);
		logic [7:0] v;
		v = (m == MOT_REV) ? PWM_FULL - d : d;
		return v;
	endfunction

	function automatic logic [7:0] fwd_plain(input logic [1:0] m, input logic [7:0] d);
		logic [7:0] v;
		v = (m == MOT_FWD) ? d : PWM_FULL - d;
		return v;
	endfunction

	function automatic void reset_model();
		st_step   = 8'd4;
		st_wait   = 8'd2;
		st_max_a  = 8'd255;
		st_max_b  = 8'd255;
		st_mot_a  = MOT_NONE;
		st_mot_b  = MOT_NONE;
		st_level  = 9'd0;
		seq_phase = PH_IDLE;
		st_cmd    = CMD_FWD;
		st_ticks  = 8'd0;
		st_pwm_a  = 8'd0;
		st_pwm_b  = 8'd0;
		st_dir_a  = 1'b0;
		st_dir_b  = 1'b0;
		st_en     = 1'b0;
		st_hold   = 8'd0;
	endfunction

	// one brake level; a direction change goes on to ramp from the held duty
	function automatic void brake_level();
		logic [8:0] s;
		logic       last;
		logic [7:0] v;
		s = step_size();
		last = (st_level <= s);
		v = last ? 8'd0 : st_level[7:0];
		if (st_cmd == CMD_BRAKE_ONE)
			st_pwm_a = fwd_plain(st_mot_a, v);
		else if (st_cmd == CMD_BRAKE_TWO)
			st_pwm_b = fwd_plain(st_mot_b, v);
		else begin
			st_pwm_a = rev_inverted(st_mot_a, v);
			st_pwm_b = rev_inverted(st_mot_b, v);
		end
		if (last) begin
			if (st_cmd <= CMD_SPIN_L) begin
				seq_phase = PH_RAMP;
				st_level = {1'b0, st_hold};
			end else
				seq_phase = PH_IDLE;
		end else
			st_level = st_level - s;
	endfunction

	function automatic logic ramp_motor(input logic [1:0] aim, input logic [7:0] top,
			input logic motor_two);
		logic [9:0] sum;
		logic       done;
		logic [7:0] e;
		sum = st_level + step_size();
		done = (sum >= top);
		e = done ? top : st_level[7:0];
		if (motor_two) begin
			st_pwm_b = rev_inverted(aim, e);
			st_dir_b = (aim == MOT_REV);
		end else begin
			st_pwm_a = rev_inverted(aim, e);
			st_dir_a = (aim == MOT_REV);
		end
		return done;
	endfunction

	function automatic void ramp_level();
		logic [1:0] ta, tb;
		logic       da, db;
		ta = aim_of(st_cmd, 1'b0);
		tb = aim_of(st_cmd, 1'b1);
		da = 1'b1;
		db = 1'b1;
		if (ta != MOT_NONE) begin
			st_mot_a = ta;
			da = ramp_motor(ta, st_max_a, 1'b0);
		end
		if (tb != MOT_NONE) begin
			st_mot_b = tb;
			db = ramp_motor(tb, st_max_b, 1'b1);
		end
		if (da && db)
			seq_phase = PH_IDLE;
		else
			st_level = st_level + step_size();
	endfunction

	function automatic void take_command(input logic [3:0] cmd, input logic [7:0] dc);
		logic need;
		st_ticks = 8'd0;
		st_cmd = cmd;
		st_level = {1'b0, dc};
		st_hold = dc;
		if (cmd <= CMD_SPIN_L) begin
			// brake first only when a running motor has to turn round
			need = (st_mot_a == counter_motion(aim_of(cmd, 1'b0))) ||
				(st_mot_b == counter_motion(aim_of(cmd, 1'b1)));
			if (need && st_mot_a != MOT_NONE && st_mot_b != MOT_NONE) begin
				seq_phase = PH_BRAKE;
				brake_level();
			end else begin
				seq_phase = PH_RAMP;
				ramp_level();
			end
		end else if (cmd == CMD_BRAKE) begin
			if (st_mot_a != MOT_NONE && st_mot_b != MOT_NONE) begin
				seq_phase = PH_BRAKE;
				brake_level();
			end
		end else if (cmd <= CMD_TWO_REV) begin
			seq_phase = PH_RAMP;
			ramp_level();
		end else if (cmd <= CMD_BRAKE_TWO) begin
			seq_phase = PH_BRAKE;
			brake_level();
		end else if (cmd == CMD_EN_ON)
			st_en = 1'b1;
		else if (cmd == CMD_EN_OFF)
			st_en = 1'b0;
	endfunction

	// advance the model by one transaction and return the bridge outputs
	function automatic drive_t bridge_step(input logic op, input logic [3:0] cmd,
			input logic [7:0] dc);
		logic       refused;
		logic [7:0] w;
		drive_t     r;
		refused = 1'b0;
		if (op == OP_CMD) begin
			if (seq_phase != PH_IDLE) begin
				refused = 1'b1;
				n_refused++;
			end else begin
				if (cmd <= CMD_EN_OFF)
					n_taken++;
				take_command(cmd, dc);
			end
		end else if (seq_phase != PH_IDLE) begin
			w = (st_wait == 8'd0) ? 8'd1 : st_wait;
			if (st_ticks != 8'd255)
				st_ticks++;
			if (st_ticks >= w) begin
				st_ticks = 8'd0;
				n_timed++;
				if (seq_phase == PH_BRAKE)
					brake_level();
				else
					ramp_level();
			end
		end
		r = '{st_pwm_a, st_pwm_b, st_dir_a, st_dir_b, st_en, seq_phase != PH_IDLE, refused};
		return r;
	endfunction

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	task automatic send_item(input logic op, input logic [3:0] cmd, input logic [7:0] dc,
			input logic typed, input drive_t fixed);
		drive_t want;
		int     gap;
		want = bridge_step(op, cmd, dc);
		if (typed)
			want = fixed;
		gap = tx_flat ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		command    <= cmd;
		start_duty <= dc;
		do @(posedge clk); while (in_stall);
		pending_drive.push_back(want);
	endtask

	// drop valid and wait until every owed result has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RAMP_STEP:  st_step = data;
			REG_WAIT_TICKS: st_wait = data;
			REG_MAX_DUTY_A: st_max_a = data;
			default:        st_max_b = data;
		endcase
	endtask

	task automatic load_regs(input logic [7:0] step, input logic [7:0] wait_n,
			input logic [7:0] top_a, input logic [7:0] top_b);
		write_reg(REG_RAMP_STEP, step);
		write_reg(REG_WAIT_TICKS, wait_n);
		write_reg(REG_MAX_DUTY_A, top_a);
		write_reg(REG_MAX_DUTY_B, top_b);
		n_settings++;
	endtask

	// start duties lean to the ends so that sequences finish in reasonable time
	function automatic logic [7:0] pick_duty();
		logic [7:0] d;
		case ($urandom_range(0, 7))
			0:       d = 8'd0;
			1:       d = 8'd255;
			2, 3:    d = 8'(255 - $urandom_range(0, 15));
			4:       d = 8'($urandom_range(0, 15));
			default: d = 8'($urandom);
		endcase
		return d;
	endfunction

	// while busy mostly tick the sequence along; while idle mostly issue commands
	task automatic run_random(input int goal, input bit tx_mode, input bit rx_mode);
		int         useful;
		int         r;
		logic       op, counts;
		logic [3:0] cmd;
		logic [7:0] dc;
		tx_flat = tx_mode;
		rx_flat = rx_mode;
		useful = 0;
		while (useful < goal) begin
			r = $urandom_range(0, 99);
			cmd = 4'($urandom);
			dc = 8'($urandom);
			if (seq_phase != PH_IDLE)
				op = (r < 92) ? OP_TICK : OP_CMD;
			else if (r < 10)
				op = OP_TICK;
			else begin
				op = OP_CMD;
				cmd = (r < 14) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
				dc = pick_duty();
			end
			counts = (op == OP_TICK) ? (seq_phase != PH_IDLE) :
				(seq_phase == PH_IDLE && cmd <= CMD_EN_OFF);
			send_item(op, cmd, dc, 1'b0, '0);
			if (counts)
				useful++;
		end
	endtask

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------
	task automatic log_mismatch(input string what, input drive_t want, input drive_t got);
		if (mismatches < 10)
			$display("mismatch (%s) at result %0d: expected pwm %0d/%0d dir %b%b en %b busy %b rej %b, got pwm %0d/%0d dir %b%b en %b busy %b rej %b",
				what, results_seen, want.pwm_a, want.pwm_b, want.dir_a, want.dir_b,
				want.enable, want.busy, want.rejected, got.pwm_a, got.pwm_b, got.dir_a,
				got.dir_b, got.enable, got.busy, got.rejected);
		mismatches++;
	endtask

	initial begin : drain_results
		int     hold;
		drive_t got, want;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = rx_flat ? 0 : $urandom_range(0, 9);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got = '{pwm_a, pwm_b, dir_a, dir_b, enable_out, busy_res, rejected};
			if (pending_drive.size() == 0)
				log_mismatch("nothing expected", '0, got);
			else begin
				want = pending_drive.pop_front();
				if (got !== want)
					log_mismatch("wrong field", want, got);
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		int k;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_RAMP_STEP;
		cfg_data   <= 8'd0;
		in_valid   <= 1'b0;
		operation  <= OP_TICK;
		command    <= CMD_FWD;
		start_duty <= 8'd0;
		mismatches = 0;
		results_seen = 0;
		n_taken = 0;
		n_refused = 0;
		n_timed = 0;
		n_settings = 0;
		tx_flat = 1'b0;
		rx_flat = 1'b0;
		long_hold_req = 1'b0;
		reset_model();

		// scripted opening: reset registers first, then fast and zero settings
		script = '{
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b1, '{8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{ROW_CMD,  CMD_UNUSED,     8'd99,  1'b1, '{8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{ROW_CMD,  CMD_EN_ON,      8'd0,   1'b1, '{8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{ROW_CMD,  CMD_BRAKE_TWO,  8'd0,   1'b1, '{8'd0,   8'd255, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{ROW_CMD,  CMD_BRAKE_ONE,  8'd3,   1'b0, '0},
			'{ROW_CMD,  CMD_BRAKE,      8'd200, 1'b0, '0},
			'{ROW_CMD,  CMD_FWD,        8'd247, 1'b0, '0},
			'{ROW_CMD,  CMD_ONE_FWD,    8'd9,   1'b1, '{8'd247, 8'd247, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}},
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b0, '0},
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b0, '0},
			'{ROW_REG,  4'(REG_RAMP_STEP),  8'd255, 1'b0, '0},
			'{ROW_REG,  4'(REG_WAIT_TICKS), 8'd1,   1'b0, '0},
			'{ROW_REG,  4'(REG_MAX_DUTY_B), 8'd200, 1'b0, '0},
			'{ROW_CMD,  CMD_REV,        8'd200, 1'b0, '0},
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b0, '0},
			'{ROW_CMD,  CMD_SPIN_R,     8'd10,  1'b0, '0},
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b0, '0},
			'{ROW_CMD,  CMD_BRAKE,      8'd128, 1'b0, '0},
			'{ROW_CMD,  CMD_TWO_REV,    8'd50,  1'b0, '0},
			'{ROW_CMD,  CMD_ONE_REV,    8'd0,   1'b0, '0},
			'{ROW_CMD,  CMD_EN_OFF,     8'd0,   1'b0, '0},
			'{ROW_CMD,  CMD_SPIN_L,     8'd255, 1'b0, '0},
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b0, '0},
			'{ROW_CMD,  CMD_UNUSED_TOP, 8'd0,   1'b0, '0},
			'{ROW_REG,  4'(REG_RAMP_STEP),  8'd0,   1'b0, '0},
			'{ROW_REG,  4'(REG_WAIT_TICKS), 8'd0,   1'b0, '0},
			'{ROW_REG,  4'(REG_MAX_DUTY_B), 8'd255, 1'b0, '0},
			'{ROW_CMD,  CMD_TWO_FWD,    8'd253, 1'b0, '0},
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b0, '0},
			'{ROW_CMD,  CMD_BRAKE_ONE,  8'd2,   1'b0, '0},
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b0, '0},
			'{ROW_TICK, CMD_FWD,        8'd0,   1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the script
		for (k = 0; k < ROWS; k++) begin
			case (script[k].kind)
				ROW_REG:  write_reg(script[k].sel[1:0], script[k].val);
				ROW_TICK: send_item(OP_TICK, script[k].sel, script[k].val,
					script[k].typed, script[k].fixed);
				default:  send_item(OP_CMD, script[k].sel, script[k].val,
					script[k].typed, script[k].fixed);
			endcase
		end

		// random traffic under reset values, both extremes, then random settings
		load_regs(8'd4, 8'd2, 8'd255, 8'd255);
		run_random(110, 1'b0, 1'b0);
		load_regs(8'd255, 8'd255, 8'd0, 8'd0);
		long_hold_req = 1'b1;
		run_random(120, 1'b1, 1'b0);
		load_regs(8'd1, 8'd1, 8'd255, 8'd255);
		run_random(120, 1'b0, 1'b1);
		for (k = 0; k < 5; k++) begin
			load_regs(8'($urandom_range(2, 96)), 8'($urandom_range(1, 3)),
				8'($urandom), 8'($urandom));
			run_random(100, k == 1, k == 3);
		end

		// hold until the tail has drained
		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d commands taken, %0d refused while busy, %0d timed ramp or brake steps",
			n_taken, n_refused, n_timed);
		$display("over %0d register settings after the script, %0d results checked",
			n_settings, results_seen);
		if (mismatches == 0)
			$display("PASS dual_hbridge_soft_ramp");
		else
			$display("FAIL dual_hbridge_soft_ramp");
		$finish;
	end

endmodule
